[rtl/tlvack_pkg.sv]
// shared constants and types for the tlv acknowledgement parser
`timescale 1ns / 1ps

package tlvack_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 1024;
  localparam int unsigned LEN_W = 11;   // packet_bytes field width
  localparam int unsigned POS_W = 9;    // saturating word counter, b reaches past any region
  localparam int unsigned IN_W  = 48;   // data_word + packet_bytes, padded to bytes
  localparam int unsigned OUT_W = 40;   // completed_id + three flags, padded to bytes

  localparam logic [31:0] MSG_KEY   = 32'h2367736d;
  localparam logic [31:0] ERR_KEY   = 32'h00727265;
  localparam logic [31:0] ALIGN_ADD = 32'd3;

  typedef enum logic [2:0] {
    PH_OUT_KEY  = 3'd0,
    PH_OUT_LEN  = 3'd1,
    PH_IN_KEY   = 3'd2,
    PH_IN_LEN   = 3'd3,
    PH_IN_VALUE = 3'd4,
    PH_DONE     = 3'd5,
    PH_DROPPED  = 3'd6
  } phase_e;

endpackage

[rtl/tlv_ack_parser_completion_tracker.sv]
// top level: key/length/value acknowledgement parser and completion tracker
`timescale 1ns / 1ps

// usage
// - slave stream carries one packet word per beat: tdata holds data_word and
//   packet_bytes, tlast marks the final word of the packet
// - each beat is parsed in the cycle it is accepted: compares and adds only,
//   so the parser takes one beat every cycle while slave tready is high
// - the beat with tlast set produces one result beat on the master stream,
//   registered, valid in the cycle after that beat is accepted; other beats
//   produce nothing
// - result: latest completed message number plus id, error and drop flags
// - the message number survives packets; all other parse state clears after
//   every last beat
// - user writes service_key via cfg_we_i / cfg_wdata_i only while idle; block does not enforce it
// - reset clears the message number, the service key and the parse state
// - receiver stall: the result register holds its beat; slave tready stays
//   high while the result register is empty or being drained, so a stall only
//   blocks input once a result is waiting and not taken
// - throughput one beat per cycle while slave tready is high, limited by the single parse step per beat
module tlv_ack_parser_completion_tracker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [31:0]                   cfg_wdata_i,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] data_word, [42:32] packet_bytes, [47:43] zero
  input  logic [tlvack_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  logic                          s_axis_tlast_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [31:0] completed_id, [32] id_updated, [33] error_reported, [34] dropped,
  // [39:35] zero
  output logic [tlvack_pkg::OUT_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned LW = tlvack_pkg::LEN_W;
  localparam int unsigned PW = tlvack_pkg::POS_W;

  // configuration and persistent state
  logic [31:0]        service_key_q;
  logic [31:0]        completed_id_q, completed_id_d;

  // per-packet parse state
  tlvack_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [LW-1:0]      region_end_q, region_end_d;
  logic [LW-1:0]      record_end_q, record_end_d;
  logic [31:0]        held_key_q, held_key_d;
  logic               fl_id_q, fl_id_d;
  logic               fl_err_q, fl_err_d;
  logic               fl_drop_q, fl_drop_d;

  // result register
  logic               out_valid_q;
  logic [31:0]        out_id_q;
  logic               out_upd_q, out_err_q, out_drop_q;

  logic               in_acc;
  logic [31:0]        w;
  logic [LW-1:0]      pk_raw, plen;
  logic [LW-1:0]      b;
  logic [31:0]        aligned;
  logic [LW:0]        tl_vstart;
  logic               tl_fail;
  logic [LW-1:0]      room;
  logic               outer_fail;
  logic [LW-1:0]      svc_len;
  logic               key_fail;
  logic               drop_final;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  assign w      = s_axis_tdata_i[31:0];
  assign pk_raw = s_axis_tdata_i[32 +: LW];
  assign plen   = (pk_raw > LW'(tlvack_pkg::MAX_PACKET_BYTES))
                  ? LW'(tlvack_pkg::MAX_PACKET_BYTES) : pk_raw;

  // byte offset of this word
  assign b       = {pos_q, 2'b00};
  assign aligned = (w + tlvack_pkg::ALIGN_ADD) & ~tlvack_pkg::ALIGN_ADD;

  // record length check, length word at byte 4 (outer) or at b (inner)
  always_comb begin
    if (phase_q == tlvack_pkg::PH_OUT_LEN) begin
      tl_vstart = (LW+1)'(8);
    end else begin
      tl_vstart = {1'b0, b} + (LW+1)'(4);
    end
    tl_fail = (tl_vstart > {1'b0, region_end_q}) ||
              ((32'({1'b0, region_end_q} - tl_vstart)) < aligned);
  end

  // outer record fit and service region clipped to packet end
  assign room       = region_end_q - LW'(8);
  assign outer_fail = (32'(room) < aligned);
  assign svc_len    = (w < 32'(room)) ? w[LW-1:0] : room;

  // not enough room left for another header
  assign key_fail = (({1'b0, b} + (LW+1)'(8)) > {1'b0, region_end_q});

  always_comb begin
    phase_d        = phase_q;
    pos_d          = pos_q;
    region_end_d   = region_end_q;
    record_end_d   = record_end_q;
    held_key_d     = held_key_q;
    fl_id_d        = fl_id_q;
    fl_err_d       = fl_err_q;
    fl_drop_d      = fl_drop_q;
    completed_id_d = completed_id_q;
    if (in_acc) begin
      case (phase_q)
        tlvack_pkg::PH_OUT_KEY: begin
          region_end_d = plen;
          held_key_d   = w;
          if (plen == '0) begin
            phase_d = tlvack_pkg::PH_DONE;
          end else if (plen < LW'(8)) begin
            fl_drop_d = 1'b1;
            phase_d   = tlvack_pkg::PH_DROPPED;
          end else begin
            phase_d = tlvack_pkg::PH_OUT_LEN;
          end
        end
        tlvack_pkg::PH_OUT_LEN: begin
          if (outer_fail) begin
            fl_drop_d = 1'b1;
            phase_d   = tlvack_pkg::PH_DROPPED;
          end else if (held_key_q == service_key_q) begin
            region_end_d = LW'(8) + svc_len;
            record_end_d = LW'(8);
            phase_d      = tlvack_pkg::PH_IN_KEY;
          end else if (tl_fail) begin
            phase_d = tlvack_pkg::PH_DONE;
          end else begin
            record_end_d = tl_vstart[LW-1:0] + aligned[LW-1:0];
            if (held_key_q == tlvack_pkg::MSG_KEY && w == 32'd4) begin
              phase_d = tlvack_pkg::PH_IN_VALUE;
            end else begin
              if (held_key_q == tlvack_pkg::ERR_KEY) fl_err_d = 1'b1;
              phase_d = tlvack_pkg::PH_IN_KEY;
            end
          end
        end
        tlvack_pkg::PH_IN_KEY: begin
          // words inside the previous record's value are skipped
          if (b >= record_end_q) begin
            if (key_fail) begin
              phase_d = tlvack_pkg::PH_DONE;
            end else begin
              held_key_d = w;
              phase_d    = tlvack_pkg::PH_IN_LEN;
            end
          end
        end
        tlvack_pkg::PH_IN_LEN: begin
          if (tl_fail) begin
            phase_d = tlvack_pkg::PH_DONE;
          end else begin
            record_end_d = tl_vstart[LW-1:0] + aligned[LW-1:0];
            if (held_key_q == tlvack_pkg::MSG_KEY && w == 32'd4) begin
              phase_d = tlvack_pkg::PH_IN_VALUE;
            end else begin
              if (held_key_q == tlvack_pkg::ERR_KEY) fl_err_d = 1'b1;
              phase_d = tlvack_pkg::PH_IN_KEY;
            end
          end
        end
        tlvack_pkg::PH_IN_VALUE: begin
          completed_id_d = w;
          fl_id_d        = 1'b1;
          phase_d        = tlvack_pkg::PH_IN_KEY;
        end
        default: begin
        end
      endcase
      if (pos_q != '1) pos_d = pos_q + PW'(1);
    end
  end

  // packet ending before its outer length word counts as dropped
  assign drop_final = fl_drop_d || (phase_d == tlvack_pkg::PH_OUT_LEN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      service_key_q  <= '0;
      completed_id_q <= '0;
      phase_q        <= tlvack_pkg::PH_OUT_KEY;
      pos_q          <= '0;
      region_end_q   <= '0;
      record_end_q   <= '0;
      held_key_q     <= '0;
      fl_id_q        <= 1'b0;
      fl_err_q       <= 1'b0;
      fl_drop_q      <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) service_key_q <= cfg_wdata_i;
      completed_id_q <= completed_id_d;
      if (in_acc && s_axis_tlast_i) begin
        // clear everything but the message number for the next packet
        phase_q      <= tlvack_pkg::PH_OUT_KEY;
        pos_q        <= '0;
        region_end_q <= '0;
        record_end_q <= '0;
        held_key_q   <= '0;
        fl_id_q      <= 1'b0;
        fl_err_q     <= 1'b0;
        fl_drop_q    <= 1'b0;
        out_valid_q  <= 1'b1;
      end else begin
        phase_q      <= phase_d;
        pos_q        <= pos_d;
        region_end_q <= region_end_d;
        record_end_q <= record_end_d;
        held_key_q   <= held_key_d;
        fl_id_q      <= fl_id_d;
        fl_err_q     <= fl_err_d;
        fl_drop_q    <= fl_drop_d;
        if (m_axis_tready_i) out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast_i) begin
      out_id_q   <= completed_id_d;
      out_upd_q  <= fl_id_d;
      out_err_q  <= fl_err_d;
      out_drop_q <= drop_final;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_drop_q, out_err_q, out_upd_q, out_id_q};

  // a last beat always leaves a result behind
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> out_valid_q)
    else $error("no result after last beat");

  // parse state starts fresh after a last beat
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tlast_i |=> pos_q == '0 && phase_q == tlvack_pkg::PH_OUT_KEY)
    else $error("parse state not cleared after last beat");

  // a record never extends past its region
  a_record_in_region: assert property (@(posedge clk_i) disable iff (!rst_ni)
    record_end_q <= region_end_q)
    else $error("record end beyond region end");

  // region never exceeds the largest packet
  a_region_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    region_end_q <= LW'(tlvack_pkg::MAX_PACKET_BYTES))
    else $error("region end beyond packet limit");

  // the result only leaves through a handshake
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_id_q))
    else $error("result lost while stalled");

endmodule
